// ----- rtl/core/mlr_pkg.sv -----
// shared types and constants of the midpoint line rasterizer
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int COLOR_BITS  = 8;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

    // one classified command between front and walker
    typedef struct packed {
        kind_t                 kind;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
        logic [ERR_BITS-1:0]   err_init;
        logic                  steep;
        logic                  x_neg;
        logic                  y_neg;
        logic [COLOR_BITS-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/mlr_front.sv -----
// front end: classifies items and does the line setup arithmetic
`timescale 1ns / 1ps
`default_nettype none

module mlr_front
    import mlr_pkg::*;
(
    input  wire logic                  kind,
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    input  wire logic [COLOR_BITS-1:0] color,
    output cmd_t                       cmd
);

    logic                  x_neg;
    logic                  y_neg;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  steep;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;

    always_comb
    begin
        x_neg = end_x < start_x;
        y_neg = end_y < start_y;
        dx    = x_neg ? (start_x - end_x) : (end_x - start_x);
        dy    = y_neg ? (start_y - end_y) : (end_y - start_y);
        // ties go to x as the major axis
        steep = dy > dx;
        major = steep ? dy : dx;
        minor = steep ? dx : dy;

        cmd.kind     = kind_t'(kind);
        cmd.start_x  = start_x;
        cmd.start_y  = start_y;
        cmd.major    = major;
        cmd.minor    = minor;
        cmd.err_init = ERR_BITS'(minor) - ERR_BITS'(major >> 1);
        cmd.steep    = steep;
        cmd.x_neg    = x_neg;
        cmd.y_neg    = y_neg;
        cmd.color    = color;
    end

endmodule

`default_nettype wire

// ----- rtl/core/mlr_queue.sv -----
// short command queue between front end and walker
`timescale 1ns / 1ps
`default_nettype none

module mlr_queue
    import mlr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire cmd_t    push_cmd,
    input  wire logic    pop,
    output cmd_t         head,
    output queue_status_t status
);

    localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_BITS-1:0] PTR_ONE  = QPTR_BITS'(1);
    localparam logic [QCNT_BITS-1:0] CNT_ONE  = QCNT_BITS'(1);
    localparam logic [QCNT_BITS-1:0] CNT_FULL = QCNT_BITS'(QUEUE_DEPTH);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_ONE;
            2'b01:   count_next = count_reg - CNT_ONE;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = count_reg == '0;
    assign status.full  = count_reg == CNT_FULL;

endmodule

`default_nettype wire

// ----- rtl/core/mlr_walker.sv -----
// back end: all-octant midpoint walker with registered pixel output
`timescale 1ns / 1ps
`default_nettype none

module mlr_walker
    import mlr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    input  wire cmd_t                   cmd,
    output logic                        cmd_pop,
    output logic                        pixel_valid,
    input  wire logic                   pixel_stall,
    output logic [COORD_BITS-1:0]       pixel_x,
    output logic [COORD_BITS-1:0]       pixel_y,
    output logic [COLOR_BITS-1:0]       pixel_color,
    output logic                        last
);

    localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

    logic                  active_reg,  active_next;
    logic [COORD_BITS-1:0] cur_x_reg,   cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg,   cur_y_next;
    logic [ERR_BITS-1:0]   err_reg,     err_next;
    logic [COORD_BITS-1:0] left_reg,    left_next;
    logic [COORD_BITS-1:0] major_reg,   major_next;
    logic [COORD_BITS-1:0] minor_reg,   minor_next;
    logic                  steep_reg,   steep_next;
    logic                  x_neg_reg,   x_neg_next;
    logic                  y_neg_reg,   y_neg_next;
    logic [COLOR_BITS-1:0] color_reg,   color_next;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_last_reg;

    logic                  take;
    logic                  emit;
    logic                  emit_last;
    logic [COORD_BITS-1:0] x_moved;
    logic [COORD_BITS-1:0] y_moved;

    assign take    = cmd_valid && (!out_valid_reg || !pixel_stall);
    assign cmd_pop = take;
    assign x_moved = x_neg_reg ? (cur_x_reg - COORD_ONE) : (cur_x_reg + COORD_ONE);
    assign y_moved = y_neg_reg ? (cur_y_reg - COORD_ONE) : (cur_y_reg + COORD_ONE);

    always_comb
    begin
        active_next = active_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_next    = err_reg;
        left_next   = left_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        steep_next  = steep_reg;
        x_neg_next  = x_neg_reg;
        y_neg_next  = y_neg_reg;
        color_next  = color_reg;
        emit        = 1'b0;
        emit_last   = 1'b0;
        if (take)
        begin
            unique case (cmd.kind)
                KIND_START:
                begin
                    cur_x_next  = cmd.start_x;
                    cur_y_next  = cmd.start_y;
                    err_next    = cmd.err_init;
                    left_next   = cmd.major;
                    major_next  = cmd.major;
                    minor_next  = cmd.minor;
                    steep_next  = cmd.steep;
                    x_neg_next  = cmd.x_neg;
                    y_neg_next  = cmd.y_neg;
                    color_next  = cmd.color;
                    active_next = cmd.major != '0;
                    emit        = 1'b1;
                    emit_last   = cmd.major == '0;
                end
                KIND_STEP:
                begin
                    // a step with no line in progress is dropped
                    if (active_reg)
                    begin
                        if (!err_reg[ERR_BITS-1])
                        begin
                            err_next = err_reg + ERR_BITS'(minor_reg)
                                       - ERR_BITS'(major_reg);
                            if (steep_reg)
                            begin
                                cur_x_next = x_moved;
                            end
                            else
                            begin
                                cur_y_next = y_moved;
                            end
                        end
                        else
                        begin
                            err_next = err_reg + ERR_BITS'(minor_reg);
                        end
                        if (steep_reg)
                        begin
                            cur_y_next = y_moved;
                        end
                        else
                        begin
                            cur_x_next = x_moved;
                        end
                        left_next   = left_reg - COORD_ONE;
                        active_next = left_reg != COORD_ONE;
                        emit        = 1'b1;
                        emit_last   = left_reg == COORD_ONE;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            left_reg      <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            steep_reg     <= 1'b0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            err_reg    <= err_next;
            left_reg   <= left_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            steep_reg  <= steep_next;
            x_neg_reg  <= x_neg_next;
            y_neg_reg  <= y_neg_next;
            color_reg  <= color_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!pixel_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg     <= cur_x_next;
            out_y_reg     <= cur_y_next;
            out_color_reg <= color_next;
            out_last_reg  <= emit_last;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign last        = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/midpoint_line_rasterizer_top.sv -----
// top level of the midpoint line rasterizer
//
// item channel (item_valid / item_stall): kind 0 starts a line from
// start_x/start_y to end_x/end_y in the given color, kind 1 asks for the
// next pixel of the current line; a step with no line in progress gives
// no pixel. pixel channel (pixel_valid / pixel_stall): one transaction per
// pixel, last marks the second endpoint.
// a start drops any line still in progress.
// an accepted transaction is written into the command queue, and its
// pixel into the output register once the walker pops it.
// throughput: one transaction per cycle while pixel_stall is low, set by
// the walker's error update (one add and a sign test).
// the front end does the endpoint setup and writes a two-entry command
// queue; the walker pops it whenever its output register is empty or is
// being taken, so a stalled receiver fills the queue and only then
// raises item_stall.
// reset clears the queue, the walker state and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_line_rasterizer_top
    import mlr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire logic                  kind,
    input  wire logic [COORD_BITS-1:0] start_x,
    input  wire logic [COORD_BITS-1:0] start_y,
    input  wire logic [COORD_BITS-1:0] end_x,
    input  wire logic [COORD_BITS-1:0] end_y,
    input  wire logic [COLOR_BITS-1:0] color,
    output logic                       pixel_valid,
    input  wire logic                  pixel_stall,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic [COLOR_BITS-1:0]      pixel_color,
    output logic                       last
);

    cmd_t          front_cmd;
    cmd_t          head_cmd;
    queue_status_t q_status;
    logic          push;
    logic          pop;

    // setup arithmetic for the incoming transaction
    mlr_front u_front (
        .kind    (kind),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .color   (color),
        .cmd     (front_cmd)
    );

    // stall only when the queue has no room
    assign item_stall = q_status.full;
    assign push       = item_valid && !q_status.full;

    mlr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .status   (q_status)
    );

    mlr_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (!q_status.empty),
        .cmd         (head_cmd),
        .cmd_pop     (pop),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last)
    );

    // queue status flags never both set
    a_queue_flags : assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.empty && q_status.full))
        else $error("queue reports empty and full together");

    // walker never pops an empty queue
    a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // an accepted transaction into an empty queue is visible next cycle
    a_push_lands : assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && q_status.empty) |=> !q_status.empty)
        else $error("accepted transaction lost in queue");

    // a pixel waiting on a stalled receiver stays offered
    a_pixel_held : assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_stall) |=> pixel_valid)
        else $error("stalled pixel dropped");

endmodule

`default_nettype wire
